// ===== design/cir2d_pkg.sv =====
`timescale 1ns / 1ps

package cir2d_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DIV_STEPS = 32;
	localparam int SQRT_STEPS = 32;
	localparam int REG_IDX_W = 1;
	localparam int REG_W = 17;

	localparam logic [REG_IDX_W-1:0] REG_SLOP = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_FRAC = 1'd1;
	localparam logic [REG_W-1:0] SLOP_RST = 17'd3277;
	localparam logic [REG_W-1:0] FRAC_RST = 17'd26214;

	typedef logic signed [31:0] fx_t;

	typedef enum logic [2:0] {
		OC_FULL        = 3'd0,
		OC_ZERO_REL    = 3'd1,
		OC_SEPARATING  = 3'd2,
		OC_NO_FRICTION = 3'd3,
		OC_ZERO_MASS   = 3'd4,
		OC_FALLBACK    = 3'd5
	} outcome_t;

	// Everything one contact carries down the pipeline.
	typedef struct packed {
		fx_t nx, ny;
		fx_t ima, imb;
		fx_t vax, vay, vbx, vby;
		fx_t dax, day, dbx, dby;
		logic [32:0] sum;
		fx_t ex;
		logic [16:0] rest;
		logic [17:0] sf, df;
		logic first, moving, targets, early, fallback, nofric;
		outcome_t code;
		fx_t rx, ry, dtr;
		fx_t mc, mj, c, j, ratio, ka, kb;
		fx_t ma, mb;
		fx_t kx, ky, ix, iy, jsf, jdfn;
		fx_t cax, cay, cbx, cby;
		fx_t pax, pay, pbx, pby;
		fx_t tx, ty, tm, jt, s;
	} ctx_t;

	function automatic fx_t sat32(input logic signed [35:0] v);
		fx_t r;
		begin
			if (v > 36'sd2147483647) begin
				r = 32'sh7fffffff;
			end else if (v < -36'sd2147483648) begin
				r = 32'sh80000000;
			end else begin
				r = v[31:0];
			end
			return r;
		end
	endfunction

	function automatic fx_t fx_neg(input fx_t a);
		return sat32(-(36'(a)));
	endfunction

	// Rounded fixed-point product, halves away from zero, saturated.
	function automatic fx_t fx_mul(input fx_t a, input fx_t b, input int f);
		logic [31:0] ua, ub;
		logic [63:0] p;
		logic neg;
		fx_t r;
		begin
			ua = a[31] ? (~a + 32'd1) : a;
			ub = b[31] ? (~b + 32'd1) : b;
			p = {32'd0, ua} * {32'd0, ub};
			p = (p + (64'd1 << (f - 1))) >> f;
			neg = a[31] ^ b[31];
			if (p > 64'h80000000) begin
				p = 64'h80000000;
			end
			if (neg) begin
				r = ~p[31:0] + 32'd1;
			end else if (p[31]) begin
				r = 32'sh7fffffff;
			end else begin
				r = p[31:0];
			end
			return r;
		end
	endfunction

endpackage

// ===== design/cir2d_if.sv =====
`timescale 1ns / 1ps

interface cir2d_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] contact_normal;
	logic [30:0] penetration_depth;
	logic [16:0] restitution;
	logic [17:0] static_friction;
	logic [17:0] dynamic_friction;
	logic [30:0] inv_mass_a;
	logic [30:0] inv_mass_b;
	logic [3:0]  contact_flags;
	logic [63:0] velocity_a;
	logic [63:0] velocity_b;
	logic [63:0] displacement_a;
	logic [63:0] displacement_b;

	modport source(output valid, contact_normal, penetration_depth, restitution,
		static_friction, dynamic_friction, inv_mass_a, inv_mass_b, contact_flags,
		velocity_a, velocity_b, displacement_a, displacement_b, input ready);
	modport sink(input valid, contact_normal, penetration_depth, restitution,
		static_friction, dynamic_friction, inv_mass_a, inv_mass_b, contact_flags,
		velocity_a, velocity_b, displacement_a, displacement_b, output ready);
endinterface

interface cir2d_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] new_velocity_a;
	logic [63:0] new_velocity_b;
	logic [63:0] correction_a;
	logic [63:0] correction_b;
	logic [2:0]  outcome;

	modport source(output valid, new_velocity_a, new_velocity_b, correction_a,
		correction_b, outcome, input ready);
	modport sink(input valid, new_velocity_a, new_velocity_b, correction_a,
		correction_b, outcome, output ready);
endinterface

// ===== design/cir2d_sqrt.sv =====
`timescale 1ns / 1ps

module cir2d_sqrt import cir2d_pkg::*; #(
	parameter int LANES = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  ctx_t in_ctx,
	input  fx_t  x [LANES],
	input  fx_t  y [LANES],
	output logic out_valid,
	output ctx_t out_ctx,
	output fx_t  root [LANES]
);

	// Squares, sum, then one result bit per stage.
	localparam int NST = SQRT_STEPS + 2;

	logic v_s [NST];
	ctx_t ctx_s [NST];
	logic [63:0] sx_s [LANES];
	logic [63:0] sy_s [LANES];
	logic [63:0] op_s [SQRT_STEPS+1][LANES];
	logic [33:0] rem_s [SQRT_STEPS+1][LANES];
	logic [31:0] root_s [SQRT_STEPS+1][LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NST; i++) begin
				v_s[i] <= 1'b0;
			end
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int i = 1; i < NST; i++) begin
				v_s[i] <= v_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s[0] <= in_ctx;
			for (int i = 1; i < NST; i++) begin
				ctx_s[i] <= ctx_s[i-1];
			end
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic [31:0] ux, uy;

		assign ux = x[l][31] ? (~x[l] + 32'd1) : x[l];
		assign uy = y[l][31] ? (~y[l] + 32'd1) : y[l];

		always_ff @(posedge clk) begin
			if (en) begin
				sx_s[l] <= {32'd0, ux} * {32'd0, ux};
				sy_s[l] <= {32'd0, uy} * {32'd0, uy};
				op_s[0][l] <= sx_s[l] + sy_s[l];
				rem_s[0][l] <= '0;
				root_s[0][l] <= '0;
			end
		end

		for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
			logic [35:0] rem2, trial, diff;
			logic ge;

			assign rem2 = {rem_s[k][l], op_s[k][l][63:62]};
			assign trial = {2'b00, root_s[k][l], 2'b01};
			assign ge = rem2 >= trial;
			assign diff = rem2 - trial;

			always_ff @(posedge clk) begin
				if (en) begin
					op_s[k+1][l] <= op_s[k][l] << 2;
					rem_s[k+1][l] <= ge ? diff[33:0] : rem2[33:0];
					root_s[k+1][l] <= {root_s[k][l][30:0], ge};
				end
			end
		end

		assign root[l] = root_s[SQRT_STEPS][l][31] ? 32'sh7fffffff
			: fx_t'(root_s[SQRT_STEPS][l]);
	end

	assign out_valid = v_s[NST-1];
	assign out_ctx = ctx_s[NST-1];

endmodule

// ===== design/cir2d_div.sv =====
`timescale 1ns / 1ps

module cir2d_div import cir2d_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int LANES = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  ctx_t              in_ctx,
	input  fx_t               a [LANES],
	input  logic signed [33:0] b [LANES],
	output logic              out_valid,
	output ctx_t              out_ctx,
	output fx_t               q [LANES]
);

	// Prep with the rounding term, one quotient bit per stage, then sign and saturation.
	localparam int NW = FRAC_BITS + 33;
	localparam int NST = DIV_STEPS + 2;

	logic v_s [NST];
	ctx_t ctx_s [NST];
	logic [33:0] rem_s [DIV_STEPS+1][LANES];
	logic [33:0] ub_s [DIV_STEPS+1][LANES];
	logic [31:0] low_s [DIV_STEPS+1][LANES];
	logic [31:0] qb_s [DIV_STEPS+1][LANES];
	logic        neg_s [DIV_STEPS+1][LANES];
	logic        ovf_s [DIV_STEPS+1][LANES];
	logic        bz_s [DIV_STEPS+1][LANES];
	fx_t         q_s [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NST; i++) begin
				v_s[i] <= 1'b0;
			end
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int i = 1; i < NST; i++) begin
				v_s[i] <= v_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s[0] <= in_ctx;
			for (int i = 1; i < NST; i++) begin
				ctx_s[i] <= ctx_s[i-1];
			end
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic [31:0]   ua;
		logic [33:0]   ubv;
		logic [NW-1:0] num;
		logic [NW-1:0] hi;
		logic [31:0]   qq;

		assign ua = a[l][31] ? (~a[l] + 32'd1) : a[l];
		assign ubv = b[l][33] ? (~b[l] + 34'd1) : b[l];
		// The half-divisor term gives round to nearest.
		assign num = (NW'(ua) << FRAC_BITS) + NW'(ubv >> 1);
		assign hi = num >> 32;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[0][l] <= 34'(hi);
				ub_s[0][l] <= ubv;
				low_s[0][l] <= num[31:0];
				qb_s[0][l] <= '0;
				neg_s[0][l] <= a[l][31] ^ b[l][33];
				ovf_s[0][l] <= hi >= NW'(ubv);
				bz_s[0][l] <= ubv == '0;
			end
		end

		for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
			logic [34:0] rem2, diff;
			logic ge;

			assign rem2 = {rem_s[k][l], low_s[k][l][31]};
			assign ge = rem2 >= {1'b0, ub_s[k][l]};
			assign diff = rem2 - {1'b0, ub_s[k][l]};

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1][l] <= ge ? diff[33:0] : rem2[33:0];
					ub_s[k+1][l] <= ub_s[k][l];
					low_s[k+1][l] <= low_s[k][l] << 1;
					qb_s[k+1][l] <= {qb_s[k][l][30:0], ge};
					neg_s[k+1][l] <= neg_s[k][l];
					ovf_s[k+1][l] <= ovf_s[k][l];
					bz_s[k+1][l] <= bz_s[k][l];
				end
			end
		end

		assign qq = (ovf_s[DIV_STEPS][l] || qb_s[DIV_STEPS][l] > 32'h80000000)
			? 32'h80000000 : qb_s[DIV_STEPS][l];

		always_ff @(posedge clk) begin
			if (en) begin
				if (bz_s[DIV_STEPS][l]) begin
					q_s[l] <= '0;
				end else if (neg_s[DIV_STEPS][l]) begin
					q_s[l] <= ~qq + 32'd1;
				end else if (qq[31]) begin
					q_s[l] <= 32'sh7fffffff;
				end else begin
					q_s[l] <= qq;
				end
			end
		end

		assign q[l] = q_s[l];
	end

	assign out_valid = v_s[NST-1];
	assign out_ctx = ctx_s[NST-1];

endmodule

// ===== design/contact_impulse_resolver_2d_unit.sv =====
`timescale 1ns / 1ps
// Throughput: one contact per cycle while the result is not stalled; the
// square-root and divider units are fully pipelined, one bit per stage, so any
// contact may follow in the next cycle.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears all valid bits and loads the slop and fraction registers.

module contact_impulse_resolver_2d_unit import cir2d_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	cir2d_in_if.sink             contact,
	cir2d_out_if.source          result
);

	localparam fx_t ONE_FX = 32'sd1 <<< FRAC_BITS;
	localparam fx_t HALF_FX = ONE_FX >>> 1;

	logic [REG_W-1:0] slop_q, frac_q;
	logic en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic v_s13, v_s14, v_s15, v_s16, v_s17, v_s18, v_s19, v_s20, v_s21, v_s22;
	logic v_s23, v_s24, v_s25;
	ctx_t c_s1, c_s2, c_s3, c_s4, c_s5, c_s6, c_s7, c_s8, c_s9, c_s10, c_s11, c_s12;
	ctx_t c_s13, c_s14, c_s15, c_s16, c_s17, c_s18, c_s19, c_s20, c_s21, c_s22;
	ctx_t c_s23, c_s24, c_s25;
	ctx_t n1, n2, n3, n4, n5, n6, n7, n8, n9, n10, n11, n12, n13;
	ctx_t n14, n15, n16, n17, n18, n19, n20, n21, n22, n23, n24, n25;

	logic sqa_v, sqb_v, diva_v, divb_v, divc_v;
	ctx_t sqa_c, sqb_c, diva_c, divb_c, divc_c;
	fx_t  sqa_x [2], sqa_y [2], sqa_r [2];
	fx_t  sqb_x [1], sqb_y [1], sqb_r [1];
	fx_t  diva_a [3], diva_q [3];
	logic signed [33:0] diva_b [3];
	fx_t  divb_a [2], divb_q [2];
	logic signed [33:0] divb_b [2];
	fx_t  divc_a [1], divc_q [1];
	logic signed [33:0] divc_b [1];

	fx_t cv4, ratio7;
	logic signed [35:0] ka7, kb7;
	logic signed [32:0] ujt21, jsf21;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slop_q <= SLOP_RST;
			frac_q <= FRAC_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SLOP: slop_q <= cfg_data;
				REG_FRAC: frac_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en = !v_s25 || result.ready;
	assign contact.ready = en;

	// Decode the contact.
	always_comb begin
		n1 = '0;
		n1.nx = contact.contact_normal[63:32];
		n1.ny = contact.contact_normal[31:0];
		n1.moving = contact.contact_flags[0] & contact.contact_flags[1];
		n1.targets = contact.contact_flags[2];
		n1.first = contact.contact_flags[3];
		n1.ima = {1'b0, contact.inv_mass_a};
		n1.imb = contact.contact_flags[0] ? {1'b0, contact.inv_mass_b} : '0;
		n1.vax = contact.velocity_a[63:32];
		n1.vay = contact.velocity_a[31:0];
		n1.vbx = n1.moving ? contact.velocity_b[63:32] : '0;
		n1.vby = n1.moving ? contact.velocity_b[31:0] : '0;
		n1.dax = contact.displacement_a[63:32];
		n1.day = contact.displacement_a[31:0];
		n1.dbx = contact.displacement_b[63:32];
		n1.dby = contact.displacement_b[31:0];
		n1.sum = {1'b0, n1.ima} + {1'b0, n1.imb};
		n1.rest = contact.restitution;
		n1.sf = contact.static_friction;
		n1.df = contact.dynamic_friction;
		n1.ex = (contact.penetration_depth > 31'(slop_q))
			? {1'b0, contact.penetration_depth - 31'(slop_q)} : '0;
		n1.code = OC_FULL;
	end

	always_comb begin
		n2 = c_s1;
		n2.rx = sat32(36'(c_s1.vbx) - 36'(c_s1.vax));
		n2.ry = sat32(36'(c_s1.vby) - 36'(c_s1.vay));
		n2.mc = fx_mul(c_s1.ex, fx_t'(frac_q), FRAC_BITS);
		if (c_s1.sum == '0) begin
			n2.early = 1'b1;
			n2.code = OC_ZERO_MASS;
		end
	end

	always_comb begin
		n3 = c_s2;
		n3.pax = fx_mul(c_s2.rx, c_s2.nx, FRAC_BITS);
		n3.pay = fx_mul(c_s2.ry, c_s2.ny, FRAC_BITS);
		if (!c_s2.early && c_s2.rx == '0 && c_s2.ry == '0) begin
			n3.early = 1'b1;
			n3.code = OC_ZERO_REL;
		end
	end

	assign cv4 = sat32(36'(c_s3.pax) + 36'(c_s3.pay));

	always_comb begin
		n4 = c_s3;
		n4.dtr = fx_neg(cv4);
		if (!c_s3.early && !cv4[31]) begin
			n4.early = 1'b1;
			n4.code = OC_SEPARATING;
		end
	end

	always_comb begin
		n5 = c_s4;
		n5.mj = fx_mul(fx_t'(ONE_FX + fx_t'(c_s4.rest)), c_s4.dtr, FRAC_BITS);
	end

	// Magnitudes for the share ratio.
	always_comb begin
		sqa_x[0] = c_s5.targets ? c_s5.dax : c_s5.vax;
		sqa_y[0] = c_s5.targets ? c_s5.day : c_s5.vay;
		sqa_x[1] = c_s5.targets ? c_s5.dbx : c_s5.vbx;
		sqa_y[1] = c_s5.targets ? c_s5.dby : c_s5.vby;
	end

	cir2d_sqrt #(.LANES(2)) u_sqrt_ratio (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s5), .in_ctx(c_s5), .x(sqa_x), .y(sqa_y),
		.out_valid(sqa_v), .out_ctx(sqa_c), .root(sqa_r)
	);

	always_comb begin
		n6 = sqa_c;
		n6.ma = sqa_r[0];
		n6.mb = sqa_r[1];
		n6.fallback = sqa_c.moving && sqa_r[0] == '0 && sqa_r[1] == '0;
	end

	// Correction magnitude, normal impulse and ratio in one divider pass.
	always_comb begin
		diva_a[0] = c_s6.mc;
		diva_b[0] = {1'b0, c_s6.sum};
		diva_a[1] = c_s6.mj;
		diva_b[1] = {1'b0, c_s6.sum};
		diva_a[2] = c_s6.targets ? c_s6.ma : c_s6.mb;
		diva_b[2] = {1'b0, {1'b0, c_s6.ma} + {1'b0, c_s6.mb}};
	end

	cir2d_div #(.FRAC_BITS(FRAC_BITS), .LANES(3)) u_div_normal (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s6), .in_ctx(c_s6), .a(diva_a), .b(diva_b),
		.out_valid(diva_v), .out_ctx(diva_c), .q(diva_q)
	);

	assign ratio7 = (diva_c.moving && !diva_c.fallback) ? diva_q[2] : HALF_FX;
	assign ka7 = 36'(ratio7) <<< 1;
	assign kb7 = (36'(ONE_FX) - 36'(ratio7)) <<< 1;

	always_comb begin
		n7 = diva_c;
		n7.c = diva_q[0];
		n7.j = diva_q[1];
		n7.ratio = ratio7;
		n7.ka = ka7[35] ? '0 : (ka7 > 36'(ONE_FX) ? ONE_FX : ka7[31:0]);
		n7.kb = kb7[35] ? '0 : (kb7 > 36'(ONE_FX) ? ONE_FX : kb7[31:0]);
	end

	always_comb begin
		n8 = c_s7;
		n8.kx = fx_mul(c_s7.nx, c_s7.c, FRAC_BITS);
		n8.ky = fx_mul(c_s7.ny, c_s7.c, FRAC_BITS);
		n8.ix = fx_mul(c_s7.nx, c_s7.j, FRAC_BITS);
		n8.iy = fx_mul(c_s7.ny, c_s7.j, FRAC_BITS);
		n8.jsf = fx_mul(c_s7.j, fx_t'(c_s7.sf), FRAC_BITS);
		n8.jdfn = fx_mul(c_s7.j, fx_t'(c_s7.df), FRAC_BITS);
	end

	always_comb begin
		n9 = c_s8;
		n9.cax = fx_mul(c_s8.kx, c_s8.ima, FRAC_BITS);
		n9.cay = fx_mul(c_s8.ky, c_s8.ima, FRAC_BITS);
		n9.cbx = fx_mul(c_s8.kx, c_s8.imb, FRAC_BITS);
		n9.cby = fx_mul(c_s8.ky, c_s8.imb, FRAC_BITS);
		n9.pax = fx_mul(c_s8.ima, c_s8.ix, FRAC_BITS);
		n9.pay = fx_mul(c_s8.ima, c_s8.iy, FRAC_BITS);
		n9.pbx = fx_mul(c_s8.imb, c_s8.ix, FRAC_BITS);
		n9.pby = fx_mul(c_s8.imb, c_s8.iy, FRAC_BITS);
		n9.jdfn = fx_neg(c_s8.jdfn);
	end

	always_comb begin
		n10 = c_s9;
		n10.cax = fx_neg(c_s9.cax);
		n10.cay = fx_neg(c_s9.cay);
		if (!c_s9.moving) begin
			n10.cbx = '0;
			n10.cby = '0;
		end
		if (!c_s9.first || c_s9.sum == '0) begin
			n10.cax = '0;
			n10.cay = '0;
			n10.cbx = '0;
			n10.cby = '0;
		end
		n10.pax = fx_mul(c_s9.pax, c_s9.ka, FRAC_BITS);
		n10.pay = fx_mul(c_s9.pay, c_s9.ka, FRAC_BITS);
		n10.pbx = fx_mul(c_s9.pbx, c_s9.kb, FRAC_BITS);
		n10.pby = fx_mul(c_s9.pby, c_s9.kb, FRAC_BITS);
	end

	// Apply the normal impulse.
	always_comb begin
		n11 = c_s10;
		if (!c_s10.early) begin
			n11.vax = sat32(36'(c_s10.vax) - 36'(c_s10.pax));
			n11.vay = sat32(36'(c_s10.vay) - 36'(c_s10.pay));
			if (c_s10.moving) begin
				n11.vbx = sat32(36'(c_s10.vbx) + 36'(c_s10.pbx));
				n11.vby = sat32(36'(c_s10.vby) + 36'(c_s10.pby));
			end
		end
	end

	always_comb begin
		n12 = c_s11;
		n12.rx = sat32(36'(c_s11.vbx) - 36'(c_s11.vax));
		n12.ry = sat32(36'(c_s11.vby) - 36'(c_s11.vay));
	end

	always_comb begin
		n13 = c_s12;
		n13.pax = fx_mul(c_s12.rx, c_s12.nx, FRAC_BITS);
		n13.pay = fx_mul(c_s12.ry, c_s12.ny, FRAC_BITS);
	end

	always_comb begin
		n14 = c_s13;
		n14.dtr = sat32(36'(c_s13.pax) + 36'(c_s13.pay));
	end

	always_comb begin
		n15 = c_s14;
		n15.pax = fx_mul(c_s14.nx, c_s14.dtr, FRAC_BITS);
		n15.pay = fx_mul(c_s14.ny, c_s14.dtr, FRAC_BITS);
	end

	always_comb begin
		n16 = c_s15;
		n16.tx = sat32(36'(c_s15.rx) - 36'(c_s15.pax));
		n16.ty = sat32(36'(c_s15.ry) - 36'(c_s15.pay));
	end

	assign sqb_x[0] = c_s16.tx;
	assign sqb_y[0] = c_s16.ty;

	cir2d_sqrt #(.LANES(1)) u_sqrt_tangent (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s16), .in_ctx(c_s16), .x(sqb_x), .y(sqb_y),
		.out_valid(sqb_v), .out_ctx(sqb_c), .root(sqb_r)
	);

	always_comb begin
		n17 = sqb_c;
		n17.tm = sqb_r[0];
		n17.nofric = (sqb_c.rx == '0 && sqb_c.ry == '0) || sqb_r[0] == '0;
	end

	// Normalize the tangent.
	always_comb begin
		divb_a[0] = c_s17.tx;
		divb_b[0] = {2'b00, c_s17.tm};
		divb_a[1] = c_s17.ty;
		divb_b[1] = {2'b00, c_s17.tm};
	end

	cir2d_div #(.FRAC_BITS(FRAC_BITS), .LANES(2)) u_div_tangent (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s17), .in_ctx(c_s17), .a(divb_a), .b(divb_b),
		.out_valid(divb_v), .out_ctx(divb_c), .q(divb_q)
	);

	always_comb begin
		n18 = divb_c;
		n18.tx = divb_q[0];
		n18.ty = divb_q[1];
	end

	always_comb begin
		n19 = c_s18;
		n19.pax = fx_mul(c_s18.rx, c_s18.tx, FRAC_BITS);
		n19.pay = fx_mul(c_s18.ry, c_s18.ty, FRAC_BITS);
	end

	always_comb begin
		n20 = c_s19;
		n20.dtr = fx_neg(sat32(36'(c_s19.pax) + 36'(c_s19.pay)));
	end

	assign divc_a[0] = c_s20.dtr;
	assign divc_b[0] = {1'b0, c_s20.sum};

	cir2d_div #(.FRAC_BITS(FRAC_BITS), .LANES(1)) u_div_friction (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s20), .in_ctx(c_s20), .a(divc_a), .b(divc_b),
		.out_valid(divc_v), .out_ctx(divc_c), .q(divc_q)
	);

	// Static friction holds while the tangent impulse stays inside the cone.
	assign ujt21 = {1'b0, (divc_q[0][31] ? (~divc_q[0] + 32'd1) : divc_q[0])};
	assign jsf21 = {divc_c.jsf[31], divc_c.jsf};

	always_comb begin
		n21 = divc_c;
		n21.jt = divc_q[0];
		if (divc_q[0] == '0) begin
			n21.nofric = 1'b1;
		end
		n21.s = (ujt21 < jsf21) ? divc_q[0] : divc_c.jdfn;
	end

	always_comb begin
		n22 = c_s21;
		n22.pax = fx_mul(c_s21.tx, c_s21.s, FRAC_BITS);
		n22.pay = fx_mul(c_s21.ty, c_s21.s, FRAC_BITS);
	end

	always_comb begin
		n23 = c_s22;
		n23.pax = fx_mul(c_s22.ima, c_s22.pax, FRAC_BITS);
		n23.pay = fx_mul(c_s22.ima, c_s22.pay, FRAC_BITS);
		n23.pbx = fx_mul(c_s22.imb, c_s22.pax, FRAC_BITS);
		n23.pby = fx_mul(c_s22.imb, c_s22.pay, FRAC_BITS);
	end

	always_comb begin
		n24 = c_s23;
		n24.pax = fx_mul(c_s23.pax, c_s23.ka, FRAC_BITS);
		n24.pay = fx_mul(c_s23.pay, c_s23.ka, FRAC_BITS);
		n24.pbx = fx_mul(c_s23.pbx, c_s23.kb, FRAC_BITS);
		n24.pby = fx_mul(c_s23.pby, c_s23.kb, FRAC_BITS);
	end

	// Apply friction and settle the outcome code.
	always_comb begin
		n25 = c_s24;
		if (!c_s24.early) begin
			n25.code = c_s24.nofric ? OC_NO_FRICTION : OC_FULL;
			if (!c_s24.nofric) begin
				n25.vax = sat32(36'(c_s24.vax) - 36'(c_s24.pax));
				n25.vay = sat32(36'(c_s24.vay) - 36'(c_s24.pay));
				if (c_s24.moving) begin
					n25.vbx = sat32(36'(c_s24.vbx) + 36'(c_s24.pbx));
					n25.vby = sat32(36'(c_s24.vby) + 36'(c_s24.pby));
				end
			end
		end
		if (c_s24.fallback && (n25.code == OC_FULL || n25.code == OC_NO_FRICTION)) begin
			n25.code = OC_FALLBACK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
			v_s16 <= 1'b0;
			v_s17 <= 1'b0;
			v_s18 <= 1'b0;
			v_s19 <= 1'b0;
			v_s20 <= 1'b0;
			v_s21 <= 1'b0;
			v_s22 <= 1'b0;
			v_s23 <= 1'b0;
			v_s24 <= 1'b0;
			v_s25 <= 1'b0;
		end else if (en) begin
			v_s1 <= contact.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= sqa_v;
			v_s7 <= diva_v;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
			v_s16 <= v_s15;
			v_s17 <= sqb_v;
			v_s18 <= divb_v;
			v_s19 <= v_s18;
			v_s20 <= v_s19;
			v_s21 <= divc_v;
			v_s22 <= v_s21;
			v_s23 <= v_s22;
			v_s24 <= v_s23;
			v_s25 <= v_s24;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= n1;
			c_s2 <= n2;
			c_s3 <= n3;
			c_s4 <= n4;
			c_s5 <= n5;
			c_s6 <= n6;
			c_s7 <= n7;
			c_s8 <= n8;
			c_s9 <= n9;
			c_s10 <= n10;
			c_s11 <= n11;
			c_s12 <= n12;
			c_s13 <= n13;
			c_s14 <= n14;
			c_s15 <= n15;
			c_s16 <= n16;
			c_s17 <= n17;
			c_s18 <= n18;
			c_s19 <= n19;
			c_s20 <= n20;
			c_s21 <= n21;
			c_s22 <= n22;
			c_s23 <= n23;
			c_s24 <= n24;
			c_s25 <= n25;
		end
	end

	assign result.valid = v_s25;
	assign result.new_velocity_a = {c_s25.vax, c_s25.vay};
	assign result.new_velocity_b = {c_s25.vbx, c_s25.vby};
	assign result.correction_a = {c_s25.cax, c_s25.cay};
	assign result.correction_b = {c_s25.cbx, c_s25.cby};
	assign result.outcome = c_s25.code;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import cir2d_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam longint ONE = 64'sd1 << FB;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 250;

	typedef struct {
		logic [63:0] normal;
		logic [30:0] depth;
		logic [16:0] rest;
		logic [17:0] sfric, dfric;
		logic [30:0] ima, imb;
		logic [3:0]  flags;
		logic [63:0] va, vb, da, db;
	} contact_t;

	typedef struct {
		logic [63:0] va, vb, ca, cb;
		outcome_t    code;
	} response_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = REG_SLOP;
	logic [REG_W-1:0] cfg_data = '0;

	cir2d_in_if  contact_bus();
	cir2d_out_if result_bus();

	contact_impulse_resolver_2d_unit u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .contact(contact_bus), .result(result_bus)
	);

	always #1 clk = ~clk;

	contact_t  pending_contacts[$];
	response_t expected_responses[$];
	longint slop_reg = SLOP_RST;
	longint frac_reg = FRAC_RST;
	int errors = 0;
	int cycles = 0;
	bit burst = 1'b0;

	// ---------------- fixed-point predictor ----------------

	function automatic longint clip(longint v);
		return v > 64'sd2147483647 ? 64'sd2147483647 :
			(v < -64'sd2147483648 ? -64'sd2147483648 : v);
	endfunction

	function automatic longint unsigned u_abs(longint v);
		return v < 0 ? longint'(-v) : v;
	endfunction

	function automatic longint sx(logic [31:0] v);
		return longint'($signed(v));
	endfunction

	function automatic logic [63:0] pack_xy(longint x, longint y);
		return {x[31:0], y[31:0]};
	endfunction

	function automatic longint fx_product(longint a, longint b);
		longint unsigned p;
		longint r;
		a = clip(a);
		b = clip(b);
		p = u_abs(a) * u_abs(b);
		p = (p + (64'd1 << (FB - 1))) >> FB;
		if (p > 64'h80000000) p = 64'h80000000;
		r = longint'(p);
		return clip(((a < 0) != (b < 0)) ? -r : r);
	endfunction

	function automatic longint fx_quotient(longint a, longint b);
		longint unsigned ua, ub, q;
		longint r;
		if (b == 0) return 0;
		ua = u_abs(clip(a));
		ub = u_abs(b);
		q = ((ua << FB) + ub / 2) / ub;
		if (q > 64'h80000000) q = 64'h80000000;
		r = longint'(q);
		return clip(((a < 0) != (b < 0)) ? -r : r);
	endfunction

	function automatic longint unsigned isqrt(longint unsigned op);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > op) bitv >>= 2;
		while (bitv != 0) begin
			if (op >= res + bitv) begin
				op -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint length_of(longint x, longint y);
		longint unsigned ax, ay, r;
		ax = u_abs(clip(x));
		ay = u_abs(clip(y));
		r = isqrt(ax * ax + ay * ay);
		return r > 64'd2147483647 ? 64'sd2147483647 : longint'(r);
	endfunction

	function automatic longint dot2(longint ax, longint ay, longint bx, longint by);
		return clip(fx_product(ax, bx) + fx_product(ay, by));
	endfunction

	function automatic longint clamp_unit(longint v);
		return v < 0 ? 0 : (v > ONE ? ONE : v);
	endfunction

	function automatic response_t resolve_contact(contact_t c);
		response_t rsp;
		longint nx, ny, pen, ima, imb, vax, vay, vbx, vby, dax, day, dbx, dby, sum;
		longint cax, cay, cbx, cby, excess, cm, kx, ky, rx, ry, cv, j, ratio;
		longint ma, mb, num, ka, kb, ix, iy, dn, tx, ty, tm, jt, s, tix, tiy;
		bit moving, done, fallback;
		outcome_t code;
		nx = sx(c.normal[63:32]);
		ny = sx(c.normal[31:0]);
		pen = c.depth;
		ima = c.ima;
		moving = c.flags[0] && c.flags[1];
		imb = c.flags[0] ? longint'(c.imb) : 0;
		vax = sx(c.va[63:32]);
		vay = sx(c.va[31:0]);
		vbx = moving ? sx(c.vb[63:32]) : 0;
		vby = moving ? sx(c.vb[31:0]) : 0;
		dax = sx(c.da[63:32]);
		day = sx(c.da[31:0]);
		dbx = sx(c.db[63:32]);
		dby = sx(c.db[31:0]);
		sum = ima + imb;
		cax = 0; cay = 0; cbx = 0; cby = 0;
		code = OC_FULL;
		done = 1'b0;
		fallback = 1'b0;
		j = 0; ka = 0; kb = 0; rx = 0; ry = 0; tm = 0; tx = 0; ty = 0;

		if (sum == 0) begin
			code = OC_ZERO_MASS;
			done = 1'b1;
		end
		if (!done) begin
			if (c.flags[3]) begin
				excess = pen - slop_reg;
				if (excess < 0) excess = 0;
				cm = fx_quotient(fx_product(excess, frac_reg), sum);
				kx = fx_product(nx, cm);
				ky = fx_product(ny, cm);
				cax = clip(-fx_product(kx, ima));
				cay = clip(-fx_product(ky, ima));
				if (moving) begin
					cbx = fx_product(kx, imb);
					cby = fx_product(ky, imb);
				end
			end
			rx = clip(vbx - vax);
			ry = clip(vby - vay);
			if (rx == 0 && ry == 0) begin
				code = OC_ZERO_REL;
				done = 1'b1;
			end
		end
		if (!done) begin
			cv = dot2(rx, ry, nx, ny);
			if (cv >= 0) begin
				code = OC_SEPARATING;
				done = 1'b1;
			end
		end
		if (!done) begin
			j = fx_quotient(fx_product(ONE + longint'(c.rest), clip(-cv)), sum);
			ratio = ONE / 2;
			if (moving) begin
				if (c.flags[2]) begin
					ma = length_of(dax, day);
					mb = length_of(dbx, dby);
					num = ma;
				end else begin
					ma = length_of(vax, vay);
					mb = length_of(vbx, vby);
					num = mb;
				end
				if (ma + mb == 0) fallback = 1'b1;
				else ratio = fx_quotient(num, ma + mb);
			end
			ka = clamp_unit(2 * ratio);
			kb = clamp_unit(2 * (ONE - ratio));
			ix = fx_product(nx, j);
			iy = fx_product(ny, j);
			vax = clip(vax - fx_product(fx_product(ima, ix), ka));
			vay = clip(vay - fx_product(fx_product(ima, iy), ka));
			if (moving) begin
				vbx = clip(vbx + fx_product(fx_product(imb, ix), kb));
				vby = clip(vby + fx_product(fx_product(imb, iy), kb));
			end
			rx = clip(vbx - vax);
			ry = clip(vby - vay);
			dn = dot2(rx, ry, nx, ny);
			tx = clip(rx - fx_product(nx, dn));
			ty = clip(ry - fx_product(ny, dn));
			tm = length_of(tx, ty);
			if ((rx == 0 && ry == 0) || tm == 0) begin
				code = OC_NO_FRICTION;
				done = 1'b1;
			end
		end
		if (!done) begin
			tx = fx_quotient(tx, tm);
			ty = fx_quotient(ty, tm);
			jt = fx_quotient(clip(-dot2(rx, ry, tx, ty)), sum);
			if (jt == 0) begin
				code = OC_NO_FRICTION;
				done = 1'b1;
			end
		end
		if (!done) begin
			s = longint'(u_abs(jt)) < fx_product(j, longint'(c.sfric)) ? jt :
				clip(-fx_product(j, longint'(c.dfric)));
			tix = fx_product(tx, s);
			tiy = fx_product(ty, s);
			vax = clip(vax - fx_product(fx_product(ima, tix), ka));
			vay = clip(vay - fx_product(fx_product(ima, tiy), ka));
			if (moving) begin
				vbx = clip(vbx + fx_product(fx_product(imb, tix), kb));
				vby = clip(vby + fx_product(fx_product(imb, tiy), kb));
			end
			code = OC_FULL;
		end
		if (fallback && (code == OC_FULL || code == OC_NO_FRICTION)) code = OC_FALLBACK;
		rsp.va = pack_xy(vax, vay);
		rsp.vb = moving ? pack_xy(vbx, vby) : 64'd0;
		rsp.ca = pack_xy(cax, cay);
		rsp.cb = pack_xy(cbx, cby);
		rsp.code = code;
		return rsp;
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 20);
		return $urandom_range(30, 150);
	endfunction

	function automatic logic [31:0] rand_scalar();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(0, 8 * 65536) - 4 * 65536;
		if (r < 90) return $urandom_range(0, 128 * 65536) - 64 * 65536;
		return $urandom;
	endfunction

	function automatic logic [63:0] rand_vec();
		return {rand_scalar(), rand_scalar()};
	endfunction

	function automatic logic [30:0] rand_inv_mass();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return '0;
		if (r < 80) return 31'($urandom_range(1, 4 * 65536));
		return 31'($urandom);
	endfunction

	function automatic contact_t random_contact();
		contact_t c;
		longint nx, ny;
		if ($urandom_range(0, 99) < 85) begin
			nx = $urandom_range(0, 65536);
			ny = longint'(isqrt((64'd1 << 32) - nx * nx));
			if ($urandom_range(0, 1)) nx = -nx;
			if ($urandom_range(0, 1)) ny = -ny;
			c.normal = pack_xy(nx, ny);
		end else begin
			c.normal = {$urandom, $urandom};
		end
		c.depth = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 262144));
		c.rest = ($urandom_range(0, 19) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
		c.sfric = ($urandom_range(0, 19) == 0) ? 18'($urandom) : 18'($urandom_range(0, 131072));
		c.dfric = ($urandom_range(0, 19) == 0) ? 18'($urandom) : 18'($urandom_range(0, 131072));
		c.ima = rand_inv_mass();
		c.imb = rand_inv_mass();
		c.flags = 4'($urandom_range(0, 15));
		c.va = rand_vec();
		c.vb = rand_vec();
		c.da = ($urandom_range(0, 9) == 0) ? 64'd0 : rand_vec();
		c.db = ($urandom_range(0, 9) == 0) ? 64'd0 : rand_vec();
		return c;
	endfunction

	// Head-on contact along +y that both bodies resolve normally.
	function automatic contact_t typical_contact();
		contact_t c;
		c.normal = pack_xy(0, ONE);
		c.depth = 31'h20000;
		c.rest = 17'h8000;
		c.sfric = 18'h8000;
		c.dfric = 18'h4000;
		c.ima = 31'h10000;
		c.imb = 31'h10000;
		c.flags = 4'b1011;
		c.va = pack_xy(ONE, 2 * ONE);
		c.vb = 64'd0;
		c.da = pack_xy(ONE / 4, -ONE / 8);
		c.db = pack_xy(-ONE / 2, ONE / 16);
		return c;
	endfunction

	task automatic load_directed();
		contact_t c;
		for (int f = 0; f < 16; f++) begin
			c = typical_contact();
			c.flags = 4'(f);
			pending_contacts.push_back(c);
		end
		c = typical_contact();
		c.ima = '0;
		c.flags = 4'b1000;
		pending_contacts.push_back(c);
		c = typical_contact();
		c.vb = c.va;
		pending_contacts.push_back(c);
		c = typical_contact();
		c.va = pack_xy(ONE, -2 * ONE);
		pending_contacts.push_back(c);
		// Purely normal approach leaves no tangential motion for friction.
		c = typical_contact();
		c.va = pack_xy(0, 2 * ONE);
		c.flags = 4'b1001;
		pending_contacts.push_back(c);
		c = typical_contact();
		c.flags = 4'b1111;
		c.da = '0;
		c.db = '0;
		pending_contacts.push_back(c);
		c = typical_contact();
		c.flags = 4'b1011;
		c.va = '0;
		pending_contacts.push_back(c);
		c.normal = '1; c.depth = '1; c.rest = '1; c.sfric = '1; c.dfric = '1;
		c.ima = '1; c.imb = '1; c.flags = '1; c.va = '1; c.vb = '1; c.da = '1; c.db = '1;
		pending_contacts.push_back(c);
		c.normal = {32'h80000000, 32'h7fffffff};
		c.va = {32'h7fffffff, 32'h80000000};
		c.vb = {32'h80000000, 32'h7fffffff};
		pending_contacts.push_back(c);
		c.normal = '0; c.depth = '0; c.rest = '0; c.sfric = '0; c.dfric = '0;
		c.ima = '0; c.imb = '0; c.flags = '0; c.va = '0; c.vb = '0; c.da = '0; c.db = '0;
		pending_contacts.push_back(c);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == REG_SLOP) slop_reg = value;
		else frac_reg = value;
	endtask

	task automatic run_phase(logic [REG_W-1:0] slop, logic [REG_W-1:0] frac, int count);
		write_reg(REG_SLOP, slop);
		write_reg(REG_FRAC, frac);
		@(posedge clk);
		cfg_we <= 1'b0;
		for (int i = 0; i < count; i++) pending_contacts.push_back(random_contact());
		while (pending_contacts.size() != 0 || contact_bus.valid ||
			expected_responses.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ---------------- driver, monitor, checker ----------------

	int send_gap = 0;
	always @(posedge clk) begin
		contact_t c;
		if (!arst_n) begin
			contact_bus.valid <= 1'b0;
		end else if (!contact_bus.valid || contact_bus.ready) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				contact_bus.valid <= 1'b0;
			end else if (pending_contacts.size() != 0) begin
				c = pending_contacts.pop_front();
				contact_bus.valid <= 1'b1;
				contact_bus.contact_normal <= c.normal;
				contact_bus.penetration_depth <= c.depth;
				contact_bus.restitution <= c.rest;
				contact_bus.static_friction <= c.sfric;
				contact_bus.dynamic_friction <= c.dfric;
				contact_bus.inv_mass_a <= c.ima;
				contact_bus.inv_mass_b <= c.imb;
				contact_bus.contact_flags <= c.flags;
				contact_bus.velocity_a <= c.va;
				contact_bus.velocity_b <= c.vb;
				contact_bus.displacement_a <= c.da;
				contact_bus.displacement_b <= c.db;
				send_gap <= gap_length();
			end else begin
				contact_bus.valid <= 1'b0;
			end
		end
	end

	int stall_left = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			result_bus.ready <= 1'b0;
		end else begin
			result_bus.ready <= 1'b1;
			stall_left <= gap_length();
		end
	end

	// Alternates random stretches with and without idling on either side; fails past CYCLE_LIMIT.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if ($urandom_range(0, 299) == 0) burst <= ~burst;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL contact_impulse_resolver_2d_unit");
			$finish;
		end
	end

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
	endtask

	always @(posedge clk) begin
		contact_t c;
		response_t want;
		if (arst_n && contact_bus.valid && contact_bus.ready) begin
			c.normal = contact_bus.contact_normal;
			c.depth = contact_bus.penetration_depth;
			c.rest = contact_bus.restitution;
			c.sfric = contact_bus.static_friction;
			c.dfric = contact_bus.dynamic_friction;
			c.ima = contact_bus.inv_mass_a;
			c.imb = contact_bus.inv_mass_b;
			c.flags = contact_bus.contact_flags;
			c.va = contact_bus.velocity_a;
			c.vb = contact_bus.velocity_b;
			c.da = contact_bus.displacement_a;
			c.db = contact_bus.displacement_b;
			expected_responses.push_back(resolve_contact(c));
		end
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (expected_responses.size() == 0) begin
				report("unexpected transfer", result_bus.new_velocity_a, '0);
			end else begin
				want = expected_responses.pop_front();
				if (result_bus.new_velocity_a !== want.va)
					report("new_velocity_a", result_bus.new_velocity_a, want.va);
				if (result_bus.new_velocity_b !== want.vb)
					report("new_velocity_b", result_bus.new_velocity_b, want.vb);
				if (result_bus.correction_a !== want.ca)
					report("correction_a", result_bus.correction_a, want.ca);
				if (result_bus.correction_b !== want.cb)
					report("correction_b", result_bus.correction_b, want.cb);
				if (result_bus.outcome !== want.code)
					report("outcome", 64'(result_bus.outcome), 64'(want.code));
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset values first, directed contacts included.
		load_directed();
		for (int i = 0; i < 250; i++) pending_contacts.push_back(random_contact());
		while (pending_contacts.size() != 0 || contact_bus.valid ||
			expected_responses.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		run_phase('0, '0, 250);
		run_phase(17'd65536, 17'd65536, 250);
		run_phase('1, '1, 250);
		run_phase(17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)), 250);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("PASS contact_impulse_resolver_2d_unit");
		end else begin
			$display("FAIL contact_impulse_resolver_2d_unit");
		end
		$finish;
	end

endmodule

// ===== contact_impulse_resolver_2d_unit.f =====
design/cir2d_pkg.sv
design/cir2d_if.sv
design/cir2d_sqrt.sv
design/cir2d_div.sv
design/contact_impulse_resolver_2d_unit.sv
verif/testbench.sv
